>>> hdl/isearch_pkg.sv
// shared constants and helpers for the interpolation search engine
`default_nettype none
package isearch_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = 10;
    localparam int KEY_W       = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int DIFF_W      = ((KEY_W > VALUE_WIDTH) ? KEY_W : VALUE_WIDTH) + 1;
    localparam int PROD_W      = DIFF_W + ADDR_W;
    localparam int CNT_W       = $clog2(ADDR_W + 1);

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // saturate a range index to the last table entry
    function automatic logic [ADDR_W-1:0] clamp_index(input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] res;
        if (int'(idx) >= TABLE_DEPTH) begin
            res = ADDR_W'(TABLE_DEPTH - 1);
        end else begin
            res = ADDR_W'(idx);
        end
        return res;
    endfunction
endpackage
`default_nettype wire

>>> hdl/isearch_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit an index
`default_nettype none
module isearch_div
    import isearch_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [DIFF_W-1:0] divisor,
    output logic                   done,
    output logic [ADDR_W-1:0]      quotient
);
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] dsh_reg;
    logic [ADDR_W-1:0] q_reg;
    logic              take;

    assign take     = (rem_reg >= dsh_reg);
    assign done     = done_reg;
    assign quotient = q_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ADDR_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift and subtract datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsh_reg <= PROD_W'(divisor) << (ADDR_W - 1);
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (take) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[ADDR_W-2:0], take};
        end
    end
endmodule
`default_nettype wire

>>> hdl/interpolation_search_engine_unit.sv
// interpolation search engine: table memory, probe sequencer and result register
// a write lands on acceptance; a search tests for an empty range, then each probe reads
// the ends, compares, multiplies and divides (not at equal ends), reads mid and compares;
// a failed range test ends the search; one search at a time, stalled by a held result
// reset clears control only; table contents are undefined until written
`default_nettype none
module interpolation_search_engine_unit
    import isearch_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_req_type,
    input  wire logic [IDX_W-1:0]        s_entry_index,
    input  wire logic signed [31:0]      s_entry_value,
    input  wire logic signed [KEY_W-1:0] s_search_key,
    input  wire logic [IDX_W-1:0]        s_range_low,
    input  wire logic [IDX_W-1:0]        s_range_high,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_found,
    output logic [IDX_W-1:0]             m_found_index
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_RLO   = 4'd2;
    localparam logic [3:0] S_RHI   = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DGO   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_RMID  = 4'd8;
    localparam logic [3:0] S_CMPM  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]                    state_reg, state_next;
    logic [ADDR_W-1:0]             low_reg, low_next;
    logic [ADDR_W-1:0]             high_reg, high_next;
    logic [ADDR_W-1:0]             mid_reg, mid_next;
    logic signed [KEY_W-1:0]       key_reg;
    logic signed [VALUE_WIDTH-1:0] vlo_reg;
    logic [DIFF_W-1:0]             num_reg, den_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic                          hit_reg, hit_next;
    logic                          m_valid_reg;
    logic                          m_found_reg;
    logic [IDX_W-1:0]              m_index_reg;

    logic signed [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] rdata_reg;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          rd_en;

    logic                          s_accept;
    logic                          div_done;
    logic [ADDR_W-1:0]             div_q;
    logic signed [DIFF_W-1:0]      key_x, vlo_x, vhi_x, vm_x;
    logic [DIFF_W-1:0]             num_c, den_c;

    assign s_ready       = (state_reg == S_IDLE);
    assign s_accept      = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_found_index = m_index_reg;

    // sign-extended operands for the range test and the interpolation
    assign key_x = DIFF_W'(key_reg);
    assign vlo_x = DIFF_W'(vlo_reg);
    assign vhi_x = DIFF_W'(rdata_reg);
    assign vm_x  = DIFF_W'(rdata_reg);
    assign num_c = DIFF_W'(key_x - vlo_x);
    assign den_c = DIFF_W'(vhi_x - vlo_x);

    // table read address
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = low_reg;
        case (state_reg)
            S_RLO: begin
                rd_en   = 1'b1;
                rd_addr = low_reg;
            end
            S_RHI: begin
                rd_en   = 1'b1;
                rd_addr = high_reg;
            end
            S_RMID: begin
                rd_en   = 1'b1;
                rd_addr = mid_reg;
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = low_reg;
            end
        endcase
    end

    // table memory, writes only while idle so no read can collide
    always_ff @(posedge aclk) begin
        if (s_accept && s_req_type == REQ_WRITE && int'(s_entry_index) < TABLE_DEPTH) begin
            table_mem[ADDR_W'(s_entry_index)] <= s_entry_value[VALUE_WIDTH-1:0];
        end
        if (rd_en) begin
            rdata_reg <= table_mem[rd_addr];
        end
    end

    isearch_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == S_DGO),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // probe sequencer
    always_comb begin
        state_next = state_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        mid_next   = mid_reg;
        hit_next   = hit_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept && s_req_type == REQ_SEARCH) begin
                    low_next   = clamp_index(s_range_low);
                    high_next  = clamp_index(s_range_high);
                    hit_next   = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = (low_reg > high_reg) ? S_OUT : S_RLO;
            end
            S_RLO: state_next = S_RHI;
            S_RHI: state_next = S_CMP;
            S_CMP: begin
                if (key_x < vlo_x || key_x > vhi_x) begin
                    state_next = S_OUT;
                end else if (vhi_x == vlo_x) begin
                    mid_next   = low_reg;
                    state_next = S_RMID;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_DGO;
            S_DGO: state_next = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    mid_next   = low_reg + div_q;
                    state_next = S_RMID;
                end
            end
            S_RMID: state_next = S_CMPM;
            S_CMPM: begin
                if (vm_x == key_x) begin
                    hit_next   = 1'b1;
                    state_next = S_OUT;
                end else if (key_x < vm_x) begin
                    // range empties when the probe sits at its low end
                    high_next  = mid_reg - 1'b1;
                    state_next = (mid_reg == low_reg) ? S_OUT : S_RLO;
                end else begin
                    low_next   = mid_reg + 1'b1;
                    state_next = (mid_reg == high_reg) ? S_OUT : S_RLO;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        low_reg  <= low_next;
        high_reg <= high_next;
        mid_reg  <= mid_next;
        hit_reg  <= hit_next;
        if (s_accept) begin
            key_reg <= s_search_key;
        end
        if (state_reg == S_CMP) begin
            vlo_reg <= vlo_reg;
            num_reg <= num_c;
            den_reg <= den_c;
        end else if (state_reg == S_RHI) begin
            vlo_reg <= rdata_reg;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= PROD_W'(num_reg) * PROD_W'(high_reg - low_reg);
        end
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            m_found_reg <= hit_reg;
            m_index_reg <= hit_reg ? IDX_W'(mid_reg) : '0;
        end
    end

`ifndef SYNTHESIS
    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RMID |-> (mid_reg >= low_reg && mid_reg <= high_reg))
        else $error("probe outside search range");
    a_miss_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_found_index == '0))
        else $error("miss reported with nonzero index");
    a_div_to_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && div_done) |=> state_reg == S_RMID)
        else $error("divider result not followed by probe read");
`endif
endmodule
`default_nettype wire

>>> tb/tb_interpolation_search_engine_unit.sv
// self-checking testbench for the interpolation search engine: directed table plus random windows
`default_nettype none
module tb_interpolation_search_engine_unit
    import isearch_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic req;
        int   idx;
        int   val;
        int   key;
        int   lo;
        int   hi;
        bit   typed;
        bit   ef;
        int   ei;
    } stim_row_t;

    typedef struct {
        logic             hit;
        logic [IDX_W-1:0] where_idx;
    } lookup_t;

    localparam int VMIN = -2147483647 - 1;
    localparam int VMAX = 2147483647;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_req_type = REQ_WRITE;
    logic [IDX_W-1:0]        s_entry_index = '0;
    logic signed [31:0]      s_entry_value = '0;
    logic signed [KEY_W-1:0] s_search_key = '0;
    logic [IDX_W-1:0]        s_range_low = '0;
    logic [IDX_W-1:0]        s_range_high = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_found;
    logic [IDX_W-1:0]        m_found_index;

    // predictor copy of the table and the queue of pending lookups
    logic signed [VALUE_WIDTH-1:0] table_copy [TABLE_DEPTH];
    lookup_t pending_lookups [$];
    int error_count = 0;
    int words_sent = 0;
    int searches_done = 0;
    int hits_seen = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    interpolation_search_engine_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_entry_index(s_entry_index),
        .s_entry_value(s_entry_value), .s_search_key(s_search_key),
        .s_range_low(s_range_low), .s_range_high(s_range_high),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_found(m_found), .m_found_index(m_found_index)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    initial begin
        #50ms;
        $display("[interpolation_search_engine_unit] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // interpolation probe sequence over the predictor table
    function automatic lookup_t interp_lookup(input int key, input int lo_in, input int hi_in);
        lookup_t res;
        longint lo, hi, vlo, vhi, vm, mid, k;
        longint unsigned num, den, span;
        res.hit = 1'b0;
        res.where_idx = '0;
        k = key;
        lo = lo_in;
        hi = hi_in;
        while (lo <= hi) begin
            vlo = table_copy[lo];
            vhi = table_copy[hi];
            if (!(vlo <= k && k <= vhi)) break;
            if (vhi == vlo) begin
                mid = lo;
            end else begin
                num = k - vlo;
                den = vhi - vlo;
                span = hi - lo;
                mid = lo + longint'((num * span) / den);
            end
            vm = table_copy[mid];
            if (vm == k) begin
                res.hit = 1'b1;
                res.where_idx = IDX_W'(mid);
                break;
            end else if (k < vm) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return res;
    endfunction

    // drive one word at the falling edge and hold it until accepted
    task automatic send_word(input stim_row_t r);
        lookup_t exp_res;
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= r.req;
        s_entry_index <= IDX_W'(r.idx);
        s_entry_value <= r.val;
        s_search_key  <= r.key;
        s_range_low   <= IDX_W'(r.lo);
        s_range_high  <= IDX_W'(r.hi);
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (r.req == REQ_WRITE) begin
            table_copy[r.idx] = r.val;
        end else begin
            exp_res = interp_lookup(r.key, r.lo, r.hi);
            if (r.typed) begin
                exp_res.hit = r.ef;
                exp_res.where_idx = IDX_W'(r.ei);
            end
            pending_lookups.push_back(exp_res);
            searches_done++;
        end
        @(negedge aclk);
    endtask

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        lookup_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("result word with nothing pending");
            end else begin
                e = pending_lookups.pop_front();
                if (m_found !== e.hit)
                    report_mismatch($sformatf("found %b, want %b", m_found, e.hit));
                if (m_found_index !== e.where_idx)
                    report_mismatch($sformatf("index %0d, want %0d",
                        m_found_index, e.where_idx));
                if (m_found === 1'b1) hits_seen++;
            end
        end
    end

    // directed words: extremes, equal ends, empty range, key outside
    stim_row_t directed_rows [20] = '{
        '{REQ_WRITE, 0, VMIN, 0, 0, 0, 0, 0, 0},
        '{REQ_WRITE, 1, -1000, 0, 0, 0, 0, 0, 0},
        '{REQ_WRITE, 2, -3, 0, 0, 0, 0, 0, 0},
        '{REQ_WRITE, 3, 0, 0, 0, 0, 0, 0, 0},
        '{REQ_WRITE, 4, 7, 0, 0, 0, 0, 0, 0},
        '{REQ_WRITE, 5, 7, 0, 0, 0, 0, 0, 0},
        '{REQ_WRITE, 6, 900, 0, 0, 0, 0, 0, 0},
        '{REQ_WRITE, 7, VMAX, 0, 0, 0, 0, 0, 0},
        '{REQ_WRITE, 1022, 5, 0, 0, 0, 0, 0, 0},
        '{REQ_WRITE, 1023, 5, 0, 0, 0, 0, 0, 0},
        '{REQ_SEARCH, 0, 0, VMIN, 0, 7, 1, 1, 0},
        '{REQ_SEARCH, 0, 0, VMAX, 0, 7, 1, 1, 7},
        '{REQ_SEARCH, 0, 0, 5, 1022, 1023, 1, 1, 1022},
        '{REQ_SEARCH, 0, 0, 6, 1022, 1023, 1, 0, 0},
        '{REQ_SEARCH, 0, 0, 0, 5, 2, 1, 0, 0},
        '{REQ_SEARCH, 0, 0, VMAX, 1023, 1023, 1, 0, 0},
        '{REQ_SEARCH, 0, 0, 3, 1023, 0, 1, 0, 0},
        '{REQ_SEARCH, 0, 0, -5, 1, 6, 0, 0, 0},
        '{REQ_SEARCH, 0, 0, 7, 0, 7, 0, 0, 0},
        '{REQ_SEARCH, 0, 0, 900, 3, 6, 0, 0, 0}
    };

    initial begin
        stim_row_t r;
        int vals [$];
        int len, base, nsearch, lo, hi, spread, phase_words;
        int fill_v, pick, mode;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) send_word(directed_rows[i]);
        s_valid <= 1'b0;
        // hold off until the directed searches have all come back
        while (pending_lookups.size() != 0) @(negedge aclk);

        // random windows: load a run of entries, then search inside it
        phase_words = 0;
        mode = 0;
        while (words_sent < 1750) begin
            if (phase_words > 200) begin
                phase_words = 0;
                mode = (mode + 1) % 4;
                tx_idle_pct  = (mode == 1) ? 61 : (mode == 3) ? 14 : 0;
                rx_stall_pct = (mode == 2) ? 61 : (mode == 3) ? 14 : 0;
            end
            len = $urandom_range(24, 2);
            base = $urandom_range(TABLE_DEPTH - len, 0);
            spread = $urandom_range(3);
            vals.delete();
            for (int i = 0; i < len; i++) begin
                if (spread == 0) fill_v = $urandom_range(8);
                else if (spread == 1) fill_v = $urandom_range(2000) - 1000;
                else fill_v = $urandom;
                vals.push_back(fill_v);
            end
            if ($urandom_range(9) != 0) vals.sort();
            if ($urandom_range(7) == 0) vals[0] = VMIN;
            if ($urandom_range(7) == 0) vals[len-1] = VMAX;
            for (int i = 0; i < len; i++) begin
                r = '{REQ_WRITE, base + i, vals[i], $urandom, $urandom_range(1023),
                      $urandom_range(1023), 0, 0, 0};
                send_word(r);
            end
            nsearch = $urandom_range(8, 3);
            for (int j = 0; j < nsearch; j++) begin
                if ($urandom_range(11) == 0) begin
                    // empty range anywhere reads nothing
                    hi = $urandom_range(1022);
                    lo = $urandom_range(1023, hi + 1);
                end else begin
                    lo = base + $urandom_range(len - 1);
                    hi = base + $urandom_range(len - 1);
                    if (lo > hi && $urandom_range(3) != 0) begin
                        pick = lo; lo = hi; hi = pick;
                    end
                end
                pick = $urandom_range(len - 1);
                case ($urandom_range(4))
                    0, 1, 2: fill_v = vals[pick];
                    3:       fill_v = vals[pick] + ($urandom_range(1) ? 1 : -1);
                    default: fill_v = $urandom;
                endcase
                r = '{REQ_SEARCH, $urandom_range(1023), $urandom, fill_v, lo, hi, 0, 0, 0};
                send_word(r);
            end
            phase_words += len + nsearch;
        end
        s_valid <= 1'b0;

        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("covered %0d words, %0d searches, %0d hits, all idle and stall phases",
            words_sent, searches_done, hits_seen);
        if (error_count == 0) begin
            $display("[interpolation_search_engine_unit] OK");
        end else begin
            $display("[interpolation_search_engine_unit] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> interpolation_search_engine_unit.f
hdl/isearch_pkg.sv
hdl/isearch_div.sv
hdl/interpolation_search_engine_unit.sv
tb/tb_interpolation_search_engine_unit.sv
